>>> rtl/c_lex_pkg.sv
// types, constants and character classes shared by the c subset lexer
package c_lex_pkg;

  localparam int unsigned KwCount   = 12;
  localparam int unsigned PrefixMax = 6;

  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_IDENT      = 3'd1,
    MODE_CONST      = 3'd2,
    MODE_SLASH      = 3'd3,
    MODE_LINE_CMT   = 3'd4,
    MODE_BLOCK      = 3'd5,
    MODE_BLOCK_STAR = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    TK_KEYWORD    = 3'd0,
    TK_IDENTIFIER = 3'd1,
    TK_CONSTANT   = 3'd2,
    TK_OPERATOR   = 3'd3,
    TK_PUNCT      = 3'd4,
    TK_INVALID    = 3'd5
  } kind_e;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_US    = 8'h5F;

  // keyword text packed first character in the low byte
  localparam logic [47:0] KW_TEXT [KwCount] = '{
    48'("tni"), 48'("rahc"), 48'("taolf"), 48'("elbuod"),
    48'("nruter"), 48'("diov"), 48'("gnol"), 48'("tcurts"),
    48'("fi"), 48'("esle"), 48'("elihw"), 48'("rof")
  };

  localparam logic [2:0] KW_LEN [KwCount] = '{
    3'd3, 3'd4, 3'd5, 3'd6, 3'd6, 3'd4, 3'd4, 3'd6, 3'd2, 3'd4, 3'd5, 3'd3
  };

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  kw;
    logic [7:0]  sym;
    logic [31:0] start;
    logic [15:0] len;
    logic [23:0] line;
    logic [15:0] idn;
    logic        last;
  } res_t;

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return c inside {8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h3C, 8'h3E, 8'h25};
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c inside {8'h28, 8'h29, 8'h7B, 8'h7D, 8'h2C, 8'h3B};
  endfunction

endpackage

>>> rtl/c_subset_lexer_top.sv
// c subset lexer: scans source bytes into token records
//
// One source byte enters per word on the input channel; a word with end_of_input set
// flushes any pending token or held-back slash and returns the scanner to its reset
// state. Each input word yields zero, one or two token records on the output channel,
// the last of which carries last_o. The input word is registered, then classified and
// scanned combinationally, and its records land in a two-entry result buffer, so the
// block sustains one byte per cycle; it holds off input only while the buffer cannot
// take all the records of the byte in hand. There is no clearing pass after reset.
module c_subset_lexer_top
  import c_lex_pkg::*;
#(
  parameter int unsigned LINE_WIDTH   = 24,
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  token_kind_o,
  output logic [3:0]  keyword_id_o,
  output logic [7:0]  symbol_char_o,
  output logic [31:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic [23:0] line_number_o,
  output logic [15:0] identifier_number_o,
  output logic        last_o
);

  // input word register
  logic       in_valid_q, in_valid_d;
  logic [7:0] char_q;
  logic       eoi_q;

  // scanner state
  mode_e                   mode_q, mode_d;
  logic [47:0]             prefix_q, prefix_d;
  logic [LENGTH_WIDTH-1:0] len_q, len_d;
  logic                    bad_q, bad_d;
  logic [LINE_WIDTH-1:0]   line_q, line_d;
  logic [31:0]             offset_q, offset_d;
  logic [31:0]             start_q, start_d;
  logic [15:0]             idcnt_q, idcnt_d;

  // result buffer
  res_t       slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0] cnt_q, cnt_d;

  logic       has_a, has_b;
  res_t       res_a, res_b, res0, res1;
  logic [1:0] n_res;
  logic       pop, fire, in_accept;
  logic [1:0] cnt_after;
  logic [31:0] len32, line32;

  assign len32  = 32'(len_q);
  assign line32 = 32'(line_q);

  // scan step
  always_comb begin
    logic        word_done;
    logic        kw_hit;
    logic [3:0]  kw_id;
    logic        fall;
    logic [15:0] idcnt_inc;
    mode_d    = mode_q;
    prefix_d  = prefix_q;
    len_d     = len_q;
    bad_d     = bad_q;
    line_d    = line_q;
    offset_d  = offset_q;
    start_d   = start_q;
    idcnt_d   = idcnt_q;
    has_a     = 1'b0;
    has_b     = 1'b0;
    res_a     = '0;
    res_b     = '0;
    word_done = 1'b0;
    fall      = 1'b0;
    kw_hit    = 1'b0;
    kw_id     = '0;

    for (int k = 0; k < KwCount; k++) begin
      if (!kw_hit && len32 == 32'(KW_LEN[k]) && prefix_q == KW_TEXT[k]) begin
        kw_hit = 1'b1;
        kw_id  = 4'(k);
      end
    end
    idcnt_inc = (idcnt_q != 16'hFFFF) ? idcnt_q + 16'd1 : idcnt_q;

    res_a.start = start_q;
    res_a.len   = len32[15:0];
    res_a.line  = line32[23:0];
    res_b.start = offset_q;
    res_b.len   = 16'd1;
    res_b.line  = line32[23:0];

    if (eoi_q) begin
      if (mode_q == MODE_IDENT || mode_q == MODE_CONST) begin
        word_done = 1'b1;
      end else if (mode_q == MODE_SLASH) begin
        has_a       = 1'b1;
        res_a.kind  = TK_OPERATOR;
        res_a.sym   = CH_SLASH;
        res_a.len   = 16'd1;
      end
    end else begin
      offset_d = offset_q + 32'd1;
      case (mode_q)
        MODE_IDENT, MODE_CONST: begin
          if (is_letter(char_q) || is_digit(char_q) || char_q == CH_US) begin
            for (int i = 0; i < PrefixMax; i++) begin
              if (len32 == 32'(i)) prefix_d[8*i +: 8] = char_q;
            end
            if (len_q != '1) len_d = len_q + LENGTH_WIDTH'(1);
            if (mode_q == MODE_CONST && !is_digit(char_q)) bad_d = 1'b1;
          end else begin
            word_done = 1'b1;
            mode_d    = MODE_NORMAL;
            fall      = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (char_q == CH_SLASH) begin
            mode_d = MODE_LINE_CMT;
          end else if (char_q == CH_STAR) begin
            mode_d = MODE_BLOCK;
          end else begin
            has_a      = 1'b1;
            res_a.kind = TK_OPERATOR;
            res_a.sym  = CH_SLASH;
            res_a.len  = 16'd1;
            mode_d     = MODE_NORMAL;
            fall       = 1'b1;
          end
        end
        MODE_LINE_CMT: begin
          if (char_q == CH_NL) begin
            if (line_q != '1) line_d = line_q + LINE_WIDTH'(1);
            mode_d = MODE_NORMAL;
          end
        end
        MODE_BLOCK, MODE_BLOCK_STAR: begin
          if (mode_q == MODE_BLOCK_STAR && char_q == CH_SLASH) begin
            mode_d = MODE_NORMAL;
          end else if (char_q == CH_STAR) begin
            mode_d = MODE_BLOCK_STAR;
          end else begin
            if (char_q == CH_NL && line_q != '1) line_d = line_q + LINE_WIDTH'(1);
            mode_d = MODE_BLOCK;
          end
        end
        default: begin
          mode_d = MODE_NORMAL;
          fall   = 1'b1;
        end
      endcase

      if (fall) begin
        if (char_q == CH_NL) begin
          if (line_q != '1) line_d = line_q + LINE_WIDTH'(1);
        end else if (is_letter(char_q) || is_digit(char_q)) begin
          mode_d   = is_letter(char_q) ? MODE_IDENT : MODE_CONST;
          start_d  = offset_q;
          prefix_d = {40'd0, char_q};
          len_d    = LENGTH_WIDTH'(1);
          bad_d    = 1'b0;
        end else if (char_q == CH_SLASH) begin
          mode_d  = MODE_SLASH;
          start_d = offset_q;
        end else if (is_oper(char_q)) begin
          has_b      = 1'b1;
          res_b.kind = TK_OPERATOR;
          res_b.sym  = char_q;
        end else if (is_punct(char_q)) begin
          has_b      = 1'b1;
          res_b.kind = TK_PUNCT;
          res_b.sym  = char_q;
        end
      end
    end

    if (word_done) begin
      has_a = 1'b1;
      if (mode_q == MODE_IDENT) begin
        if (kw_hit) begin
          res_a.kind = TK_KEYWORD;
          res_a.kw   = kw_id;
        end else begin
          res_a.kind = TK_IDENTIFIER;
          res_a.idn  = idcnt_inc;
          idcnt_d    = idcnt_inc;
        end
      end else begin
        res_a.kind = bad_q ? TK_INVALID : TK_CONSTANT;
      end
    end

    if (eoi_q) begin
      mode_d   = MODE_NORMAL;
      prefix_d = '0;
      len_d    = '0;
      bad_d    = 1'b0;
      line_d   = LINE_WIDTH'(1);
      offset_d = '0;
      start_d  = '0;
      idcnt_d  = '0;
    end
  end

  // order the records of this byte
  always_comb begin
    res0      = has_a ? res_a : res_b;
    res0.last = !(has_a && has_b);
    res1      = res_b;
    res1.last = 1'b1;
    n_res     = 2'(has_a) + 2'(has_b);
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign cnt_after   = cnt_q - 2'(pop);
  assign fire        = in_valid_q && ((3'(cnt_after) + 3'(n_res)) <= 3'd2);
  assign in_ready_o  = !in_valid_q || fire;
  assign in_accept   = in_valid_i && in_ready_o;
  assign in_valid_d  = in_accept ? 1'b1 : (fire ? 1'b0 : in_valid_q);

  // result buffer update
  always_comb begin
    slot0_d = pop ? slot1_q : slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_after;
    if (fire) begin
      cnt_d = cnt_after + n_res;
      case (cnt_after)
        2'd0: begin
          slot0_d = res0;
          slot1_d = res1;
        end
        2'd1: begin
          slot1_d = res0;
        end
        default: begin
          slot1_d = slot1_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      cnt_q      <= 2'd0;
      mode_q     <= MODE_NORMAL;
      prefix_q   <= '0;
      len_q      <= '0;
      bad_q      <= 1'b0;
      line_q     <= LINE_WIDTH'(1);
      offset_q   <= '0;
      start_q    <= '0;
      idcnt_q    <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      cnt_q      <= cnt_d;
      if (fire) begin
        mode_q   <= mode_d;
        prefix_q <= prefix_d;
        len_q    <= len_d;
        bad_q    <= bad_d;
        line_q   <= line_d;
        offset_q <= offset_d;
        start_q  <= start_d;
        idcnt_q  <= idcnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      char_q <= char_code_i;
      eoi_q  <= end_of_input_i;
    end
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign token_kind_o        = slot0_q.kind;
  assign keyword_id_o        = slot0_q.kw;
  assign symbol_char_o       = slot0_q.sym;
  assign start_offset_o      = slot0_q.start;
  assign token_length_o      = slot0_q.len;
  assign line_number_o       = slot0_q.line;
  assign identifier_number_o = slot0_q.idn;
  assign last_o              = slot0_q.last;

endmodule
